### sv/t0pb_pkg.sv
// Shared constants and helpers for the timer 0 and port B interrupt unit.
`default_nettype none

package t0pb_pkg;

    // INTCON bit positions
    localparam int unsigned GIE_BIT  = 7;
    localparam int unsigned T0IE_BIT = 5;
    localparam int unsigned INTE_BIT = 4;
    localparam int unsigned RBIE_BIT = 3;
    localparam int unsigned T0IF_BIT = 2;
    localparam int unsigned INTF_BIT = 1;
    localparam int unsigned RBIF_BIT = 0;

    // OPTION bit positions
    localparam int unsigned INTEDG_BIT = 6;
    localparam int unsigned T0CS_BIT   = 5;
    localparam int unsigned PSA_BIT    = 3;

    localparam int unsigned ACC_W      = 9;
    localparam logic [8:0]  ACC_MAX    = 9'd511;
    localparam int unsigned IRQ_VECTOR = 4;

    typedef logic [ACC_W-1:0] acc_t;

    // Prescale ratio: 1 when the prescaler is given to the watchdog, else 2 << PS.
    function automatic acc_t ratio_of(input logic [7:0] opt);
        acc_t r;
        if (opt[PSA_BIT]) begin
            r = 9'd1;
        end else begin
            r = 9'd2 << opt[2:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/timer0_and_port_b_interrupt_unit_top.sv
// Top level of the timer 0 and port B interrupt unit.
`default_nettype none

// Timer 0 and port B interrupt unit. Each input beat describes one retired
// instruction (cycles used, OPTION, INTCON, TRISB, PORTB, TMR0, PC) and gives
// exactly one result beat: updated INTCON, TMR0 and PC plus an optional stack
// push. In order the unit checks the RB7..RB4 change interrupt, restarts the
// prescale accumulator on a ratio change, advances TMR0 by at most one count
// with its overflow interrupt, and checks the RB0/INT edge selected by INTEDG.
// A taken interrupt sets its flag, clears GIE, pushes the old PC and loads PC
// with vector 4; as GIE is cleared at most one interrupt fires per beat.
// Timing: a beat lands in an input register, all work is one short combinational
// pass (one 10-bit add and saturate, one 9-bit compare and subtract, an 8-bit
// increment) into the result register. One beat per clock is sustained while
// m_ready keeps the result register draining; m_valid rises once the beat has
// passed the input register and been written into the result register. The
// result register lets a new beat enter while a finished result waits for m_ready.
// No configuration port; the history state resets to zero.
module timer0_and_port_b_interrupt_unit_top #(
    parameter int PC_WIDTH = 13
) (
    input  wire                 aclk,
    input  wire                 aresetn,

    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  [1:0]          s_cycles_used,
    input  wire  [7:0]          s_option_value,
    input  wire  [7:0]          s_intcon_value,
    input  wire  [7:0]          s_trisb_value,
    input  wire  [7:0]          s_port_b_value,
    input  wire  [7:0]          s_tmr0_value,
    input  wire  [PC_WIDTH-1:0] s_pc_value,

    output logic                m_valid,
    input  wire                 m_ready,
    output logic [7:0]          m_new_intcon,
    output logic [7:0]          m_new_tmr0,
    output logic [PC_WIDTH-1:0] m_new_pc,
    output logic                m_push_valid,
    output logic [PC_WIDTH-1:0] m_push_address
);
    import t0pb_pkg::*;

    localparam logic [PC_WIDTH-1:0] VECTOR_PC = PC_WIDTH'(IRQ_VECTOR);

    // input register
    logic                in_valid_reg;
    logic [1:0]          in_cyc_reg;
    logic [7:0]          in_opt_reg;
    logic [7:0]          in_ic_reg;
    logic [7:0]          in_tris_reg;
    logic [7:0]          in_pb_reg;
    logic [7:0]          in_tmr_reg;
    logic [PC_WIDTH-1:0] in_pc_reg;

    // result register
    logic                out_valid_reg;
    logic [7:0]          out_ic_reg;
    logic [7:0]          out_tmr_reg;
    logic [PC_WIDTH-1:0] out_pc_reg;
    logic                out_push_reg;
    logic [PC_WIDTH-1:0] out_push_addr_reg;

    // history state
    acc_t                acc_reg;
    acc_t                last_ratio_reg;
    logic [3:0]          prev_rb_high_reg;
    logic                prev_rb0_reg;

    logic                advance;
    logic                s_accept;

    // combinational pass
    logic [3:0]          rb_now;
    logic                rb_irq;
    logic [7:0]          ic1, ic2, ic3;
    logic                t0cs;
    logic [ACC_W:0]      acc_sum;
    acc_t                acc_sat;
    acc_t                ratio;
    acc_t                acc_pre;
    logic                tick;
    acc_t                acc_next;
    logic [7:0]          tmr_next;
    logic                t0_irq;
    logic                rb0_now;
    logic                int_irq;
    logic                any_irq;

    // stage handshakes: the input register moves on when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        // RB7..RB4 change on input pins only
        rb_now = in_pb_reg[7:4];
        rb_irq = in_ic_reg[GIE_BIT] && in_ic_reg[RBIE_BIT] &&
                 (|((rb_now ^ prev_rb_high_reg) & in_tris_reg[7:4]));
        ic1 = in_ic_reg;
        if (rb_irq) begin
            ic1[GIE_BIT]  = 1'b0;
            ic1[RBIF_BIT] = 1'b1;
        end

        // prescale accumulator, saturating at its maximum
        t0cs    = in_opt_reg[T0CS_BIT];
        acc_sum = {1'b0, (t0cs ? acc_t'(0) : acc_reg)} + {{(ACC_W-1){1'b0}}, in_cyc_reg};
        acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
        ratio   = ratio_of(in_opt_reg);
        acc_pre = (ratio != last_ratio_reg) ? 9'd1 : acc_sat;

        // timer 0 count and overflow
        tick     = !t0cs && (acc_pre >= ratio);
        acc_next = tick ? (acc_pre - ratio) : acc_pre;
        tmr_next = tick ? (in_tmr_reg + 8'd1) : in_tmr_reg;
        t0_irq   = tick && (tmr_next == 8'd0) && ic1[GIE_BIT] && ic1[T0IE_BIT];
        ic2 = ic1;
        if (t0_irq) begin
            ic2[GIE_BIT]  = 1'b0;
            ic2[T0IF_BIT] = 1'b1;
        end

        // RB0/INT edge, polarity from INTEDG
        rb0_now = in_pb_reg[0];
        int_irq = ic2[GIE_BIT] && ic2[INTE_BIT] && (rb0_now != prev_rb0_reg) &&
                  (rb0_now == in_opt_reg[INTEDG_BIT]);
        ic3 = ic2;
        if (int_irq) begin
            ic3[GIE_BIT]  = 1'b0;
            ic3[INTF_BIT] = 1'b1;
        end

        // GIE clears on the first one, so the return address is always the input PC
        any_irq = rb_irq || t0_irq || int_irq;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            acc_reg          <= '0;
            last_ratio_reg   <= '0;
            prev_rb_high_reg <= '0;
            prev_rb0_reg     <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg    <= 1'b1;
                acc_reg          <= acc_next;
                last_ratio_reg   <= ratio;
                prev_rb_high_reg <= rb_now;
                prev_rb0_reg     <= rb0_now;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cyc_reg  <= s_cycles_used;
            in_opt_reg  <= s_option_value;
            in_ic_reg   <= s_intcon_value;
            in_tris_reg <= s_trisb_value;
            in_pb_reg   <= s_port_b_value;
            in_tmr_reg  <= s_tmr0_value;
            in_pc_reg   <= s_pc_value;
        end
        if (advance) begin
            out_ic_reg        <= ic3;
            out_tmr_reg       <= tmr_next;
            out_pc_reg        <= any_irq ? VECTOR_PC : in_pc_reg;
            out_push_reg      <= any_irq;
            out_push_addr_reg <= any_irq ? in_pc_reg : '0;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_new_intcon   = out_ic_reg;
    assign m_new_tmr0     = out_tmr_reg;
    assign m_new_pc       = out_pc_reg;
    assign m_push_valid   = out_push_reg;
    assign m_push_address = out_push_addr_reg;

endmodule

`default_nettype wire

### sv/t0pb_checker.sv
// Port-level checker for the timer 0 and port B interrupt unit, with its bind.
`default_nettype none

module t0pb_checker #(
    parameter int PC_WIDTH = 13
) (
    input wire                aclk,
    input wire                aresetn,
    input wire                m_valid,
    input wire                m_ready,
    input wire [7:0]          m_new_intcon,
    input wire [PC_WIDTH-1:0] m_new_pc,
    input wire                m_push_valid,
    input wire [PC_WIDTH-1:0] m_push_address
);
    import t0pb_pkg::*;

    // a taken interrupt always lands on the vector
    a_push_vector: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_push_valid) |-> (m_new_pc == PC_WIDTH'(IRQ_VECTOR)))
        else $error("push without vector load");

    // a taken interrupt always leaves GIE clear
    a_push_gie: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_push_valid) |-> !m_new_intcon[GIE_BIT])
        else $error("push with GIE still set");

    // no push, no return address
    a_no_push_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_push_valid) |-> (m_push_address == '0))
        else $error("stale push address");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_new_pc) &&
                                   $stable(m_new_intcon) && $stable(m_push_valid)))
        else $error("result changed under stall");

endmodule

bind timer0_and_port_b_interrupt_unit_top t0pb_checker #(
    .PC_WIDTH(PC_WIDTH)
) u_t0pb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_new_intcon  (m_new_intcon),
    .m_new_pc      (m_new_pc),
    .m_push_valid  (m_push_valid),
    .m_push_address(m_push_address)
);

`default_nettype wire
